// File: src/assert_macros.svh
// assertion macros shared by the quaternion unit rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define QAU_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");
`define QAU_ASSERT_NO_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");
`else
`define QAU_ASSERT(lbl, clk, rst, prop)
`define QAU_ASSERT_NO_RST(lbl, clk, prop)
`endif

`endif

// File: src/qau_pkg.sv
// types, stage records and rounding/saturation helpers for the quaternion unit
// no dependencies
package qau_pkg;

  localparam int unsigned SumW = 52;

  typedef logic signed [31:0]     word_t;
  typedef logic signed [63:0]     prod_t;
  typedef logic signed [SumW-1:0] sum_t;

  typedef enum logic [2:0] {
    MODE_MUL   = 3'd0,
    MODE_ROT   = 3'd1,
    MODE_DOT   = 3'd2,
    MODE_ADD   = 3'd3,
    MODE_SCALE = 3'd4,
    MODE_CONJ  = 3'd5
  } mode_t;

  localparam word_t WORD_MAX = 32'sh7fff_ffff;
  localparam word_t WORD_MIN = 32'sh8000_0000;
  localparam prod_t HALF_16  = 64'sd32768;
  localparam prod_t HALF_15  = 64'sd16384;

  typedef struct packed {
    logic  ov;
    word_t val;
  } sat_t;

  // after the product array: operands kept for add and conjugate
  typedef struct {
    mode_t mode;
    word_t a[4];
    word_t b[4];
    prod_t p[16];
  } s1_t;

  // after rounding and summing: final results for all but rotate
  typedef struct {
    mode_t mode;
    word_t res[4];
    logic  ov;
    word_t m[9];
    word_t v[3];
  } s2_t;

  // after the matrix-vector products
  typedef struct {
    mode_t mode;
    word_t res[4];
    logic  ov;
    prod_t q[9];
  } s3_t;

  typedef struct {
    word_t r[4];
    logic  ov;
  } res_t;

  // round to nearest, ties up, dropping 16 fraction bits
  function automatic sum_t rnd16(input prod_t p);
    prod_t t;
    t = p + HALF_16;
    return sum_t'(t >>> 16);
  endfunction

  // doubled term: drop 15 bits instead of 16
  function automatic sum_t rnd15(input prod_t p);
    prod_t t;
    t = p + HALF_15;
    return sum_t'(t >>> 15);
  endfunction

  function automatic sum_t ext(input word_t w);
    return sum_t'(w);
  endfunction

  function automatic sat_t sat32(input sum_t v);
    sat_t r;
    if (v[SumW-1:31] != {(SumW-31){v[SumW-1]}}) begin
      r.ov  = 1'b1;
      r.val = v[SumW-1] ? WORD_MIN : WORD_MAX;
    end else begin
      r.ov  = 1'b0;
      r.val = word_t'(v[31:0]);
    end
    return r;
  endfunction

endpackage

// File: src/qau_if.sv
// request and result channels of the quaternion unit
// depends on qau_pkg
interface qau_req_if;
  import qau_pkg::*;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  word_t      a_x;
  word_t      a_y;
  word_t      a_z;
  word_t      a_w;
  word_t      b_x;
  word_t      b_y;
  word_t      b_z;
  word_t      b_w;

  modport source (output valid, mode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                  input ready);
  modport sink   (input valid, mode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                  output ready);
endinterface

interface qau_rsp_if;
  import qau_pkg::*;
  logic  valid;
  logic  ready;
  word_t r_x;
  word_t r_y;
  word_t r_z;
  word_t r_w;
  logic  overflow;

  modport source (output valid, r_x, r_y, r_z, r_w, overflow, input ready);
  modport sink   (input valid, r_x, r_y, r_z, r_w, overflow, output ready);
endinterface

// File: src/qau_prod.sv
// first stage: sixteen-entry 32x32 product array feeding all multiply modes
// depends on qau_pkg and qau_req_if
module qau_prod (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  qau_req_if.sink       req,
  output logic          vout,
  output qau_pkg::s1_t  s1
);
  import qau_pkg::*;

  s1_t   s1_next;
  mode_t mode_in;
  word_t av[4];
  word_t bv[4];
  word_t yv[4];

  assign req.ready = en;
  assign mode_in   = mode_t'(req.mode);

  always_comb begin
    av = '{req.a_x, req.a_y, req.a_z, req.a_w};
    bv = '{req.b_x, req.b_y, req.b_z, req.b_w};
    // rotate squares A against itself; the upper triangle holds its products
    for (int j = 0; j < 4; j++) begin
      yv[j] = (mode_in == MODE_ROT) ? av[j] : bv[j];
    end
    s1_next.mode = mode_in;
    s1_next.a    = av;
    s1_next.b    = bv;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        s1_next.p[i*4+j] = prod_t'(av[i]) * prod_t'(yv[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= s1_next;
    end
  end

endmodule

// File: src/qau_combine.sv
// second stage: rounds products, forms sums for every mode but rotate and the nine
// rotation coefficients, all saturated; depends on qau_pkg
module qau_combine (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vin,
  input  qau_pkg::s1_t  s1,
  output logic          vout,
  output qau_pkg::s2_t  s2
);
  import qau_pkg::*;

  s2_t  s2_next;
  sum_t r16[16];
  sum_t ab, ac, ad, bc, bd, cd;
  sum_t m_sum[9];
  sat_t m_sat[9];
  sum_t sel[4];
  sat_t res_sat[4];
  logic ov_rot;

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      r16[k] = rnd16(s1.p[k]);
    end
    ab = rnd15(s1.p[1]);
    ac = rnd15(s1.p[2]);
    ad = rnd15(s1.p[3]);
    bc = rnd15(s1.p[6]);
    bd = rnd15(s1.p[7]);
    cd = rnd15(s1.p[11]);

    // diagonal of the array holds aa, bb, cc, dd in rotate mode
    m_sum[0] =  r16[0] - r16[5] - r16[10] + r16[15];
    m_sum[1] =  ab - cd;
    m_sum[2] =  ac + bd;
    m_sum[3] =  ab + cd;
    m_sum[4] = -r16[0] + r16[5] - r16[10] + r16[15];
    m_sum[5] =  bc - ad;
    m_sum[6] =  ac - bd;
    m_sum[7] =  ad + bc;
    m_sum[8] = -r16[0] - r16[5] + r16[10] + r16[15];
    ov_rot = 1'b0;
    for (int k = 0; k < 9; k++) begin
      m_sat[k] = sat32(m_sum[k]);
      ov_rot   = ov_rot | m_sat[k].ov;
    end

    for (int k = 0; k < 4; k++) begin
      sel[k] = '0;
    end
    unique case (s1.mode)
      MODE_MUL: begin
        sel[0] =  r16[3] + r16[6] - r16[9]  + r16[12];
        sel[1] = -r16[2] + r16[7] + r16[8]  + r16[13];
        sel[2] =  r16[1] - r16[4] + r16[11] + r16[14];
        sel[3] = -r16[0] - r16[5] - r16[10] + r16[15];
      end
      MODE_ROT: begin
      end
      MODE_DOT: begin
        sel[0] = r16[0] + r16[5] + r16[10] + r16[15];
      end
      MODE_ADD: begin
        for (int k = 0; k < 4; k++) begin
          sel[k] = ext(s1.a[k]) + ext(s1.b[k]);
        end
      end
      MODE_SCALE: begin
        sel[0] = r16[3];
        sel[1] = r16[7];
        sel[2] = r16[11];
        sel[3] = r16[15];
      end
      MODE_CONJ: begin
        sel[0] = -ext(s1.a[0]);
        sel[1] = -ext(s1.a[1]);
        sel[2] = -ext(s1.a[2]);
        sel[3] =  ext(s1.a[3]);
      end
      default: begin
      end
    endcase

    s2_next.mode = s1.mode;
    s2_next.ov   = (s1.mode == MODE_ROT) ? ov_rot : 1'b0;
    for (int k = 0; k < 4; k++) begin
      res_sat[k]     = sat32(sel[k]);
      s2_next.res[k] = res_sat[k].val;
      s2_next.ov     = s2_next.ov | res_sat[k].ov;
    end
    for (int k = 0; k < 9; k++) begin
      s2_next.m[k] = m_sat[k].val;
    end
    for (int k = 0; k < 3; k++) begin
      s2_next.v[k] = s1.b[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2 <= s2_next;
    end
  end

endmodule

// File: src/qau_rotate.sv
// third and fourth stages: coefficient-by-vector products, then rounding,
// summing and the output register; depends on qau_pkg
module qau_rotate (
  input  logic          clk,
  input  logic          rst,
  input  logic          en_mul,
  input  logic          en_out,
  input  logic          vin,
  input  qau_pkg::s2_t  s2,
  output logic          v_mul,
  output logic          out_valid,
  output qau_pkg::res_t out
);
  import qau_pkg::*;

  s3_t  s3;
  s3_t  s3_next;
  res_t out_next;
  sum_t row_sum[3];
  sat_t row_sat[3];

  always_comb begin
    s3_next.mode = s2.mode;
    s3_next.res  = s2.res;
    s3_next.ov   = s2.ov;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s3_next.q[i*3+j] = prod_t'(s2.m[i*3+j]) * prod_t'(s2.v[j]);
      end
    end
  end

  always_comb begin
    out_next.r  = s3.res;
    out_next.ov = s3.ov;
    for (int i = 0; i < 3; i++) begin
      row_sum[i] = rnd16(s3.q[i*3]) + rnd16(s3.q[i*3+1]) + rnd16(s3.q[i*3+2]);
      row_sat[i] = sat32(row_sum[i]);
    end
    if (s3.mode == MODE_ROT) begin
      for (int i = 0; i < 3; i++) begin
        out_next.r[i] = row_sat[i].val;
        out_next.ov   = out_next.ov | row_sat[i].ov;
      end
      out_next.r[3] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_mul     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_mul) begin
        v_mul <= vin;
      end
      if (en_out) begin
        out_valid <= v_mul;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_mul) begin
      s3 <= s3_next;
    end
    if (en_out) begin
      out <= out_next;
    end
  end

endmodule

// File: src/quaternion_arithmetic_unit.sv
// quaternion arithmetic unit in signed Q16.16: multiply, rotate, dot, add,
// scale, conjugate, all results saturated to 32 bits
// depends on qau_pkg, qau_if, qau_prod, qau_combine, qau_rotate, assert_macros.svh
//
// usage:
//   req carries mode and quaternions A, B; rsp returns r_x..r_w and overflow.
//   both channels move a request when valid and ready are high at a clock edge.
//   four register stages: product array, round and sum, coefficient-by-vector
//   products, round/sum and output register. the first stage loads at the
//   accepting edge and rsp.valid rises when the output register loads; one
//   request per cycle is sustained while rsp.ready stays high.
//   each stage takes new data whenever it is empty or its successor moves, so
//   bubbles are squeezed out and req.ready only drops with all four stages full
//   and the receiver holding rsp.ready low. a stalled result holds its value.
//   synchronous reset empties every stage; nothing is in flight afterwards.
`include "assert_macros.svh"
module quaternion_arithmetic_unit (
  input  logic     clk,
  input  logic     rst,
  qau_req_if.sink  req,
  qau_rsp_if.source rsp
);
  import qau_pkg::*;

  logic en_prod, en_comb, en_mul, en_out;
  logic v_prod, v_comb, v_mul, out_valid;
  logic any_valid, all_full;
  s1_t  s1;
  s2_t  s2;
  res_t res;

  assign en_out  = !out_valid || rsp.ready;
  assign en_mul  = !v_mul     || en_out;
  assign en_comb = !v_comb    || en_mul;
  assign en_prod = !v_prod    || en_comb;

  assign any_valid = v_prod || v_comb || v_mul || out_valid;
  assign all_full  = v_prod && v_comb && v_mul && out_valid;

  qau_prod u_prod (
    .clk  (clk),
    .rst  (rst),
    .en   (en_prod),
    .req  (req),
    .vout (v_prod),
    .s1   (s1)
  );

  qau_combine u_combine (
    .clk  (clk),
    .rst  (rst),
    .en   (en_comb),
    .vin  (v_prod),
    .s1   (s1),
    .vout (v_comb),
    .s2   (s2)
  );

  qau_rotate u_rotate (
    .clk       (clk),
    .rst       (rst),
    .en_mul    (en_mul),
    .en_out    (en_out),
    .vin       (v_comb),
    .s2        (s2),
    .v_mul     (v_mul),
    .out_valid (out_valid),
    .out       (res)
  );

  assign rsp.valid    = out_valid;
  assign rsp.r_x      = res.r[0];
  assign rsp.r_y      = res.r[1];
  assign rsp.r_z      = res.r[2];
  assign rsp.r_w      = res.r[3];
  assign rsp.overflow = res.ov;

  `QAU_ASSERT_NO_RST(a_reset_empties, clk, $past(rst) |-> !any_valid)
  `QAU_ASSERT(a_stall_only_when_full, clk, rst, !req.ready |-> all_full && !rsp.ready)
  `QAU_ASSERT(a_last_stage_moves, clk, rst, v_mul && en_out |=> out_valid)

endmodule
